// ----- rtl/core/rvc_pkg.sv -----
// Shared types and constants for the radial vignetting correction block.
// No dependencies; imported by rvc_sqrt_pipe, rvc_div_pipe and the top level.
`default_nettype none

package rvc_pkg;

  // Fraction bits of the radius and of the interpolation weight.
  localparam int FRAC_BITS = 15;
  localparam int FRAC_ONE  = 32768;
  // One half pixel in the radius format.
  localparam int HALF_PIXEL = 16384;
  // Radius scale register width (unsigned Q1.16).
  localparam int SCALE_W = 17;
  // Interpolated gain, unsigned Q2.29.
  localparam int GAIN_W = 32;
  // Dividend shift that lines a channel up with the gain format.
  localparam int DIV_SHIFT = 29;
  // Quotient bits kept: eight data bits and one overflow bit.
  localparam int DIV_STEPS = 9;
  // Partial remainder width of the divider.
  localparam int NUM_W = 40;
  localparam int LANES = 3;
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REG_CENTER_X       = 2'd0,
    REG_CENTER_Y       = 2'd1,
    REG_RADIUS_SCALE   = 2'd2,
    REG_PROFILE_LENGTH = 2'd3
  } cfg_reg_t;

  // Fields of a word that ride along with the radius computation.
  typedef struct packed {
    logic        mode;
    logic [6:0]  idx;
    logic [15:0] value;
    logic [7:0]  chan_a;
    logic [7:0]  chan_b;
    logic [7:0]  chan_c;
  } carry_t;

endpackage

`default_nettype wire

// ----- rtl/core/rvc_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on rvc_pkg for the sideband type carried with each word.
`default_nettype none

module rvc_sqrt_pipe
  import rvc_pkg::*;
#(
  parameter int RB = 28
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [2*RB-1:0]   in_x,
  input  wire carry_t            in_side,
  output logic                   out_valid,
  output logic [RB-1:0]          out_root,
  output carry_t                 out_side
);

  logic              v    [RB];
  logic [RB+1:0]     rem  [RB];
  logic [RB-1:0]     root [RB];
  logic [2*RB-1:0]   x    [RB];
  carry_t            side [RB];

  for (genvar k = 0; k < RB; k++) begin : g_step
    logic            v_i;
    logic [RB+1:0]   rem_i;
    logic [RB-1:0]   root_i;
    logic [2*RB-1:0] x_i;
    carry_t          side_i;
    logic [RB+3:0]   cur;
    logic [RB+3:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = in_x;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign x_i    = x[k-1];
      assign side_i = side[k-1];
    end

    assign cur   = {rem_i, x_i[2*RB-1 -: 2]};
    assign trial = (RB+4)'({root_i, 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (take) begin
          rem[k]  <= (RB+2)'(cur - trial);
          root[k] <= {root_i[RB-2:0], 1'b1};
        end else begin
          rem[k]  <= cur[RB+1:0];
          root[k] <= {root_i[RB-2:0], 1'b0};
        end
        x[k]    <= x_i << 2;
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = v[RB-1];
  assign out_root  = root[RB-1];
  assign out_side  = side[RB-1];

endmodule

`default_nettype wire

// ----- rtl/core/rvc_div_pipe.sv -----
// Pipelined restoring divider for three channels sharing one divisor.
// Depends on rvc_pkg for the divider widths and the lane count.
`default_nettype none

module rvc_div_pipe
  import rvc_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               adv,
  input  wire logic                               in_valid,
  input  wire logic [GAIN_W-1:0]                  in_gain,
  input  wire logic [LANES-1:0][7:0]              in_chan,
  output logic                                    out_valid,
  output logic [LANES-1:0][DIV_STEPS-1:0]         out_quo
);

  logic                                v    [DIV_STEPS];
  logic [GAIN_W-1:0]                   gain [DIV_STEPS];
  logic [LANES-1:0][NUM_W-1:0]         num  [DIV_STEPS];
  logic [LANES-1:0][DIV_STEPS-1:0]     quo  [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic                            v_i;
    logic [GAIN_W-1:0]               gain_i;
    logic [LANES-1:0][NUM_W-1:0]     num_i;
    logic [LANES-1:0][DIV_STEPS-1:0] quo_i;
    logic [NUM_W-1:0]                trial;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign gain_i = in_gain;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign num_i[l] = NUM_W'(in_chan[l]) << DIV_SHIFT;
      end
      assign quo_i  = '0;
    end else begin : g_next
      assign v_i    = v[s-1];
      assign gain_i = gain[s-1];
      assign num_i  = num[s-1];
      assign quo_i  = quo[s-1];
    end

    assign trial = NUM_W'(gain_i) << (DIV_STEPS - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv) begin
        v[s] <= v_i;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          if (num_i[l] >= trial) begin
            num[s][l] <= num_i[l] - trial;
            quo[s][l] <= {quo_i[l][DIV_STEPS-2:0], 1'b1};
          end else begin
            num[s][l] <= num_i[l];
            quo[s][l] <= {quo_i[l][DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        gain[s] <= gain_i;
      end
    end
  end

  assign out_valid = v[DIV_STEPS-1];
  assign out_quo   = quo[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/radial_vignetting_correction.sv -----
// Top level of the radial vignetting correction block.
// Depends on rvc_pkg, rvc_sqrt_pipe and rvc_div_pipe.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  mode, profile_index, profile_value, column, row,
//                                 chan_a, chan_b, chan_c
//   output   out_valid/out_ready  out_a, out_b, out_c
//   config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle while in_ready is high. A pixel word passes the
// input stages, the one-bit-per-stage root of RB bits (RB is 28 at 12 coordinate
// bits), the radius, table and gain stages, the nine-stage divider and the output.
// Reset is synchronous, clears the valid bits and sets the configuration to its
// defaults; the gain table is not cleared and must be loaded before pixels use it.
// The whole pipeline advances together; a two-entry output buffer lets a new
// word enter while a finished result waits, and in_ready drops only when both
// entries are full.
`default_nettype none

module radial_vignetting_correction
  import rvc_pkg::*;
#(
  parameter int PROFILE_DEPTH = 128,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [6:0]            profile_index,
  input  wire logic [15:0]           profile_value,
  input  wire logic [COORD_BITS-1:0] column,
  input  wire logic [COORD_BITS-1:0] row,
  input  wire logic [7:0]            chan_a,
  input  wire logic [7:0]            chan_b,
  input  wire logic [7:0]            chan_c,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_a,
  output logic [7:0]                 out_b,
  output logic [7:0]                 out_c,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [16:0]           cfg_data
);

  // Widths that follow from the parameters.
  localparam int SQ_W  = 2 * COORD_BITS + 1;              // dx*dx + dy*dy
  localparam int DW    = SQ_W + 2 * FRAC_BITS;            // radicand
  localparam int RB    = (DW + 1) / 2;                    // root bits
  localparam int PW    = RB + 1 + SCALE_W;                // scaled radius product
  localparam int RW    = PW - 16;                         // radius, Q.15
  localparam int NRW   = RW - FRAC_BITS;                  // integer part of radius
  localparam int AW    = $clog2(PROFILE_DEPTH);
  localparam int NW    = $clog2(PROFILE_DEPTH + 1);
  localparam int IW    = ((AW > 7) ? AW : 7) + 1;
  localparam int CW0   = (NRW > NW) ? NRW : NW;
  localparam int CW    = ((CW0 > 8) ? CW0 : 8) + 1;

  // Config regs. Writes must arrive only while the block is idle; not enforced.
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [SCALE_W-1:0]    radius_scale;
  logic [7:0]            profile_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      radius_scale   <= SCALE_W'(65536);
      profile_length <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:       center_x       <= COORD_BITS'(cfg_data[11:0]);
        REG_CENTER_Y:       center_y       <= COORD_BITS'(cfg_data[11:0]);
        REG_RADIUS_SCALE:   radius_scale   <= cfg_data;
        REG_PROFILE_LENGTH: profile_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; it holds only when the output skid entry is full.
  logic adv;
  logic skid_valid;

  assign adv      = !skid_valid;
  assign in_ready = adv;

  // Stage 1: register the accepted word.
  logic                  v1;
  carry_t                c1;
  logic [COORD_BITS-1:0] col1;
  logic [COORD_BITS-1:0] row1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1   <= '{mode: mode, idx: profile_index, value: profile_value,
                chan_a: chan_a, chan_b: chan_b, chan_c: chan_c};
      col1 <= column;
      row1 <= row;
    end
  end

  // Stage 2: absolute offsets from the image center.
  logic                  v2;
  carry_t                c2;
  logic [COORD_BITS-1:0] dx2;
  logic [COORD_BITS-1:0] dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2  <= c1;
      dx2 <= (col1 >= center_x) ? col1 - center_x : center_x - col1;
      dy2 <= (row1 >= center_y) ? row1 - center_y : center_y - row1;
    end
  end

  // Stage 3: squares of the offsets.
  logic                    v3;
  carry_t                  c3;
  logic [2*COORD_BITS-1:0] dxx3;
  logic [2*COORD_BITS-1:0] dyy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3   <= c2;
      dxx3 <= (2*COORD_BITS)'(dx2) * (2*COORD_BITS)'(dx2);
      dyy3 <= (2*COORD_BITS)'(dy2) * (2*COORD_BITS)'(dy2);
    end
  end

  // Stage 4: squared distance.
  logic            v4;
  carry_t          c4;
  logic [SQ_W-1:0] d2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c4   <= c3;
      d2_4 <= SQ_W'(dxx3) + SQ_W'(dyy3);
    end
  end

  // Distance in Q.15: the root of the squared distance shifted up by 30 bits.
  logic [2*RB-1:0] radicand;
  logic            v_sq;
  logic [RB-1:0]   root_sq;
  carry_t          c_sq;

  assign radicand = (2*RB)'({d2_4, {(2*FRAC_BITS){1'b0}}});

  rvc_sqrt_pipe #(
    .RB (RB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v4),
    .in_x      (radicand),
    .in_side   (c4),
    .out_valid (v_sq),
    .out_root  (root_sq),
    .out_side  (c_sq)
  );

  // Stage 5: add half a pixel and scale to the profile's image size.
  logic          v5;
  carry_t        c5;
  logic [PW-1:0] prod5;
  logic [RB:0]   r0;

  assign r0 = (RB+1)'(root_sq) + (RB+1)'(HALF_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5    <= c_sq;
      prod5 <= PW'(r0) * PW'(radius_scale);
    end
  end

  // Stage 6: choose the two table entries and the interpolation weight.
  // A radius below one pixel reads entry 0 alone, and a radius past the table
  // reads the last entry alone; both are a weight of zero on the upper entry.
  logic [RW-1:0]        rad;
  logic [CW-1:0]        nr_c;
  logic [CW-1:0]        nrm1_c;
  logic [CW-1:0]        n_c;
  logic [CW-1:0]        nm1_c;
  logic [FRAC_BITS-1:0] frac;
  logic [AW-1:0]        a0_next;
  logic [AW-1:0]        a1_next;
  logic [FRAC_BITS-1:0] f_next;

  assign rad    = prod5[PW-1:16];
  assign nr_c   = CW'(rad[RW-1:FRAC_BITS]);
  assign frac   = rad[FRAC_BITS-1:0];
  assign nrm1_c = nr_c - CW'(1);
  assign nm1_c  = n_c - CW'(1);

  always_comb begin
    priority if (profile_length == 8'd0) begin
      n_c = CW'(1);
    end else if (CW'(profile_length) > CW'(PROFILE_DEPTH)) begin
      n_c = CW'(PROFILE_DEPTH);
    end else begin
      n_c = CW'(profile_length);
    end
  end

  always_comb begin
    priority if (nr_c == '0) begin
      a0_next = '0;
      a1_next = '0;
      f_next  = '0;
    end else if (nr_c < n_c) begin
      a0_next = nrm1_c[AW-1:0];
      a1_next = nr_c[AW-1:0];
      f_next  = frac;
    end else begin
      a0_next = nm1_c[AW-1:0];
      a1_next = nm1_c[AW-1:0];
      f_next  = '0;
    end
  end

  logic                 v6;
  carry_t               c6;
  logic [AW-1:0]        a0_6;
  logic [AW-1:0]        a1_6;
  logic [FRAC_BITS-1:0] f6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c6   <= c5;
      a0_6 <= a0_next;
      a1_6 <= a1_next;
      f6   <= f_next;
    end
  end

  // Stage 7: gain table. Load words write here, at the same place where pixels
  // read, so every pixel sees exactly the loads that came before it.
  logic [15:0]          gain_mem [PROFILE_DEPTH];
  logic [IW-1:0]        widx;
  logic                 wr_en;
  logic                 pv7;
  logic [LANES-1:0][7:0] ch7;
  logic [15:0]          t0_7;
  logic [15:0]          t1_7;
  logic [FRAC_BITS-1:0] f7;

  assign widx  = IW'(c6.idx);
  assign wr_en = adv && v6 && !c6.mode && (widx < IW'(PROFILE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gain_mem[widx[AW-1:0]] <= c6.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_7 <= gain_mem[a0_6];
      t1_7 <= gain_mem[a1_6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv7 <= 1'b0;
    end else if (adv) begin
      pv7 <= v6 && c6.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch7 <= {c6.chan_c, c6.chan_b, c6.chan_a};
      f7  <= f6;
    end
  end

  // Stage 8: weighted entries.
  logic                  pv8;
  logic [LANES-1:0][7:0] ch8;
  logic [GAIN_W-1:0]     m0_8;
  logic [GAIN_W-1:0]     m1_8;
  logic [15:0]           inv_f;

  assign inv_f = 16'(FRAC_ONE) - 16'(f7);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv8 <= 1'b0;
    end else if (adv) begin
      pv8 <= pv7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch8  <= ch7;
      m0_8 <= GAIN_W'(t0_7) * GAIN_W'(inv_f);
      m1_8 <= GAIN_W'(t1_7) * GAIN_W'(f7);
    end
  end

  // Stage 9: interpolated gain in Q2.29.
  logic                  pv9;
  logic [LANES-1:0][7:0] ch9;
  logic [GAIN_W-1:0]     gain9;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv9 <= 1'b0;
    end else if (adv) begin
      pv9 <= pv8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch9   <= ch8;
      gain9 <= m0_8 + m1_8;
    end
  end

  // Divide each channel by the gain. A zero gain yields an all-ones quotient,
  // which the overflow bit turns into full scale below.
  logic                             dv;
  logic [LANES-1:0][DIV_STEPS-1:0]  quo;
  logic [LANES-1:0][7:0]            res;

  rvc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pv9),
    .in_gain   (gain9),
    .in_chan   (ch9),
    .out_valid (dv),
    .out_quo   (quo)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_sat
    assign res[l] = quo[l][DIV_STEPS-1] ? CHAN_MAX : quo[l][7:0];
  end

  // Output register with one skid entry behind it.
  logic [LANES-1:0][7:0] obuf;
  logic [LANES-1:0][7:0] sbuf;
  logic                  ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid     <= 1'b0;
      skid_valid <= 1'b0;
    end else if (ovalid && out_ready) begin
      if (skid_valid) begin
        obuf       <= sbuf;
        skid_valid <= 1'b0;
      end else if (dv && adv) begin
        obuf <= res;
      end else begin
        ovalid <= 1'b0;
      end
    end else if (dv && adv) begin
      if (ovalid) begin
        sbuf       <= res;
        skid_valid <= 1'b1;
      end else begin
        obuf   <= res;
        ovalid <= 1'b1;
      end
    end
  end

  assign out_valid = ovalid;
  assign out_a     = obuf[0];
  assign out_b     = obuf[1];
  assign out_c     = obuf[2];

endmodule

`default_nettype wire

// ----- rtl/core/rvc_checker.sv -----
// Port-level checks for the radial vignetting correction block, with its bind.
// Depends only on the top level's ports.
`default_nettype none

module rvc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_a,
  input wire logic [7:0] out_b,
  input wire logic [7:0] out_c
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_a) && $stable(out_b) && $stable(out_c))
    else $error("output word changed while stalled");

  // Input backpressure only happens with a result waiting at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input held off with no result waiting");

  // Backpressure has cleared in the cycle after the consumer takes a word.
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready)
    else $error("input still held off after output drained");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind radial_vignetting_correction rvc_checker u_rvc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_a     (out_a),
  .out_b     (out_b),
  .out_c     (out_c)
);

`default_nettype wire
